/* hdl/smds_pkg.sv */
package smds_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 8;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SEL_LOW  = 2'd0,
        SEL_HIGH = 2'd1,
        SEL_BOTH = 2'd2
    } sel_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } cmd_t;

endpackage

/* hdl/smds_in_if.sv */
interface smds_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [1:0]         stack_sel;
    logic signed [31:0] push_value;
    logic [7:0]         position;

    modport source (output valid, output func, output stack_sel, output push_value,
                    output position, input ready);
    modport sink (input valid, input func, input stack_sel, input push_value,
                  input position, output ready);
endinterface

/* hdl/smds_out_if.sv */
interface smds_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         low_count;
    logic [7:0]         high_count;
    logic               low_empty;
    logic               high_empty;
    logic               store_full;

    modport source (output valid, output status, output read_value, output low_count,
                    output high_count, output low_empty, output high_empty,
                    output store_full, input ready);
    modport sink (input valid, input status, input read_value, input low_count,
                  input high_count, input low_empty, input high_empty,
                  input store_full, output ready);
endinterface

/* hdl/smds_ctrl.sv */
module smds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output smds_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat did not move to execution");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending response beat overwritten");

    a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (state_reg == S_RESP && !in_ready))
        else $error("execution not followed by response state");

endmodule

/* hdl/smds_datapath.sv */
module smds_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smds_pkg::cmd_t        cmd,
    input  logic [1:0]            func,
    input  logic [1:0]            stack_sel,
    input  logic signed [31:0]    push_value,
    input  logic [7:0]            position,
    output logic [1:0]            status,
    output logic signed [31:0]    read_value,
    output logic [7:0]            low_count,
    output logic [7:0]            high_count,
    output logic                  low_empty,
    output logic                  high_empty,
    output logic                  store_full
);

    localparam int CW = smds_pkg::CNT_W;
    localparam int AW = smds_pkg::ADDR_W;
    localparam int PW = smds_pkg::CMP_W;
    localparam int DW = smds_pkg::DATA_WIDTH;

    logic [DW-1:0]         mem [smds_pkg::DEPTH];

    smds_pkg::func_t       func_reg;
    smds_pkg::sel_t        sel_reg;
    logic [DW-1:0]         value_reg;
    logic [7:0]            pos_reg;

    logic [CW-1:0]         low_fill_reg;
    logic [CW-1:0]         low_fill_next;
    logic [CW-1:0]         high_fill_reg;
    logic [CW-1:0]         high_fill_next;

    smds_pkg::status_t     status_reg;
    smds_pkg::status_t     status_next;
    logic                  got_reg;
    logic                  got_next;
    logic [DW-1:0]         rd_data_reg;

    logic [1:0]            rsp_status_reg;
    logic signed [31:0]    rsp_value_reg;
    logic [7:0]            rsp_low_reg;
    logic [7:0]            rsp_high_reg;
    logic                  rsp_low_empty_reg;
    logic                  rsp_high_empty_reg;
    logic                  rsp_full_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [CW:0]           total;
    logic                  is_full;
    logic [CW-1:0]         low_m1;
    logic [CW-1:0]         high_top;
    logic [PW-1:0]         pos_c;
    logic [PW-1:0]         pos_m1;
    logic [PW-1:0]         pos_from_top;
    logic [CW-1:0]         sel_cnt;

    assign total        = (CW + 1)'(low_fill_reg) + (CW + 1)'(high_fill_reg);
    assign is_full      = (total >= (CW + 1)'(smds_pkg::DEPTH));
    assign low_m1       = low_fill_reg - CW'(1);
    assign high_top     = CW'(smds_pkg::DEPTH) - high_fill_reg;
    assign pos_c        = PW'(pos_reg);
    assign pos_m1       = pos_c - PW'(1);
    assign pos_from_top = PW'(smds_pkg::DEPTH) - pos_c;
    assign sel_cnt      = (sel_reg == smds_pkg::SEL_LOW) ? low_fill_reg : high_fill_reg;

    always_comb
    begin
        status_next    = smds_pkg::ST_OK;
        got_next       = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = '0;
        low_fill_next  = low_fill_reg;
        high_fill_next = high_fill_reg;
        case (func_reg)
            smds_pkg::FUNC_PUSH:
            begin
                if (is_full)
                begin
                    status_next = smds_pkg::ST_FULL;
                end
                else if (sel_reg == smds_pkg::SEL_LOW)
                begin
                    mem_we        = 1'b1;
                    mem_addr      = low_fill_reg[AW-1:0];
                    low_fill_next = low_fill_reg + CW'(1);
                end
                else if (sel_reg == smds_pkg::SEL_HIGH)
                begin
                    mem_we         = 1'b1;
                    mem_addr       = AW'(smds_pkg::DEPTH - 1) - high_fill_reg[AW-1:0];
                    high_fill_next = high_fill_reg + CW'(1);
                end
            end
            smds_pkg::FUNC_POP:
            begin
                if (sel_reg == smds_pkg::SEL_LOW || sel_reg == smds_pkg::SEL_HIGH)
                begin
                    if (sel_cnt == '0)
                    begin
                        status_next = smds_pkg::ST_EMPTY;
                    end
                    else if (sel_reg == smds_pkg::SEL_LOW)
                    begin
                        got_next      = 1'b1;
                        mem_addr      = low_m1[AW-1:0];
                        low_fill_next = low_m1;
                    end
                    else
                    begin
                        got_next       = 1'b1;
                        mem_addr       = high_top[AW-1:0];
                        high_fill_next = high_fill_reg - CW'(1);
                    end
                end
            end
            smds_pkg::FUNC_READ:
            begin
                if (sel_reg == smds_pkg::SEL_LOW || sel_reg == smds_pkg::SEL_HIGH)
                begin
                    if (sel_cnt == '0)
                    begin
                        status_next = smds_pkg::ST_EMPTY;
                    end
                    else if (pos_c == '0 || pos_c > PW'(sel_cnt))
                    begin
                        status_next = smds_pkg::ST_BAD_POS;
                    end
                    else if (sel_reg == smds_pkg::SEL_LOW)
                    begin
                        got_next = 1'b1;
                        mem_addr = pos_m1[AW-1:0];
                    end
                    else
                    begin
                        got_next = 1'b1;
                        mem_addr = pos_from_top[AW-1:0];
                    end
                end
            end
            smds_pkg::FUNC_CLEAR:
            begin
                if (sel_reg == smds_pkg::SEL_LOW || sel_reg == smds_pkg::SEL_BOTH)
                begin
                    low_fill_next = '0;
                end
                if (sel_reg == smds_pkg::SEL_HIGH || sel_reg == smds_pkg::SEL_BOTH)
                begin
                    high_fill_next = '0;
                end
            end
            default:
            begin
                status_next = smds_pkg::ST_OK;
            end
        endcase
    end

    // Captured command beat.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= smds_pkg::func_t'(func);
            sel_reg   <= smds_pkg::sel_t'(stack_sel);
            value_reg <= DW'(push_value);
            pos_reg   <= position;
        end
    end

    // Shared store: at most one write or one registered read per operation.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (cmd.exec && got_next)
        begin
            rd_data_reg <= mem[mem_addr];
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            got_reg    <= got_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_fill_reg  <= '0;
            high_fill_reg <= '0;
        end
        else if (cmd.exec)
        begin
            low_fill_reg  <= low_fill_next;
            high_fill_reg <= high_fill_next;
        end
    end

    // Response register; the fill counts already hold their new values here.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_status_reg     <= status_reg;
            rsp_value_reg      <= got_reg ? 32'($signed(rd_data_reg)) : 32'sd0;
            rsp_low_reg        <= 8'(low_fill_reg);
            rsp_high_reg       <= 8'(high_fill_reg);
            rsp_low_empty_reg  <= (low_fill_reg == '0);
            rsp_high_empty_reg <= (high_fill_reg == '0);
            rsp_full_reg       <= (total == (CW + 1)'(smds_pkg::DEPTH));
        end
    end

    assign status     = rsp_status_reg;
    assign read_value = rsp_value_reg;
    assign low_count  = rsp_low_reg;
    assign high_count = rsp_high_reg;
    assign low_empty  = rsp_low_empty_reg;
    assign high_empty = rsp_high_empty_reg;
    assign store_full = rsp_full_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        total <= (CW + 1)'(smds_pkg::DEPTH))
        else $error("stacks overlap in the shared store");

endmodule

/* hdl/shared_memory_double_stack_unit.sv */
// Two LIFO stacks sharing one store of smds_pkg::DEPTH words. The low stack
// grows up from entry zero and the high stack grows down from the top entry.
//
// Channels: cmd is a valid/ready sink carrying func, stack_sel, push_value and
// position; rsp is a valid/ready source carrying status, read_value, both
// counts and the empty and full flags. A beat moves on a rising edge with
// valid and ready both high, and every command beat yields one response beat.
//
// Timing: a command is captured at its accepting edge, executed against the
// store in the next cycle (one write or one registered read), and its response
// is then loaded into the output register once that register is free, which
// raises rsp.valid. The controller finishes capture, execute and respond for
// one command before it takes the next.
//
// Reset clears both fill counts and the response valid; the store is not
// cleared and needs no clearing pass. When the receiver stalls, the pending
// response holds in the output register while the next command is still
// accepted and executed; it then waits in the response state until the
// output register frees up, and cmd.ready stays low meanwhile.
module shared_memory_double_stack_unit (
    input  logic       clk,
    input  logic       rst_n,
    smds_in_if.sink    cmd,
    smds_out_if.source rsp
);

    smds_pkg::cmd_t ctrl_cmd;

    // Sequencer: capture, execute, respond.
    smds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctrl_cmd)
    );

    // Store, fill counters and response register.
    smds_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .func       (cmd.func),
        .stack_sel  (cmd.stack_sel),
        .push_value (cmd.push_value),
        .position   (cmd.position),
        .status     (rsp.status),
        .read_value (rsp.read_value),
        .low_count  (rsp.low_count),
        .high_count (rsp.high_count),
        .low_empty  (rsp.low_empty),
        .high_empty (rsp.high_empty),
        .store_full (rsp.store_full)
    );

endmodule
